@@ sv/sonar_serial_range_frame_parser_unit_defines.svh @@
// Assertion macros shared by the range frame parser RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef SONAR_SERIAL_RANGE_FRAME_PARSER_UNIT_DEFINES_SVH
`define SONAR_SERIAL_RANGE_FRAME_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SSRFP_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define SSRFP_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/ssrfp_pkg.sv @@
// Shared types, codes and character constants for the range frame parser.
// No dependencies; ssrfp_frame_check, ssrfp_seq and the top level import this package.
package ssrfp_pkg;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NOT_ENABLED = 3'd1,
    ST_BUSY        = 3'd2,
    ST_DIGIT_ERR   = 3'd3,
    ST_BAD_FRAME   = 3'd4
  } status_t;

  // Request kinds carried by the req_type field.
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_BYTE  = 1'b1;

  // Frame characters.
  localparam logic [7:0] CHAR_R    = 8'h52;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam int RANGE_W = 10;

  // One input item as seen by the sequencer once it leaves the input register.
  typedef struct packed {
    logic       go;
    logic       req_type;
    logic [7:0] rx_byte;
  } step_t;

  // The result that the current item produces, if any.
  typedef struct packed {
    logic               emit;
    status_t            status;
    logic [RANGE_W-1:0] range_inches;
    logic               trigger_pulse;
  } res_t;

  // Decimal weight of a digit position: hundreds first.
  function automatic logic [6:0] digit_weight(input int unsigned k);
    logic [6:0] w;
    case (k)
      0:       w = 7'd100;
      1:       w = 7'd10;
      default: w = 7'd1;
    endcase
    return w;
  endfunction

endpackage

@@ sv/ssrfp_if.sv @@
// Valid/ready channel interfaces of the range frame parser.
// Depends on nothing; used by the top level of the block.

// Request channel: start commands and received serial bytes.
interface ssrfp_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;
  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

// Result channel.
interface ssrfp_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [9:0] range_inches;
  logic       trigger_pulse;
  modport source (output valid, output status, output range_inches, output trigger_pulse,
                  input ready);
  modport sink   (input valid, input status, input range_inches, input trigger_pulse,
                  output ready);
endinterface

// Configuration write channel for the enable register.
interface ssrfp_cfg_if;
  logic valid;
  logic ready;
  logic sensor_enabled;
  modport source (output valid, output sensor_enabled, input ready);
  modport sink   (input valid, input sensor_enabled, output ready);
endinterface

@@ sv/ssrfp_frame_check.sv @@
// Combinational check and decode of a completed range frame.
// Depends on ssrfp_pkg for status codes, characters and digit weights.
module ssrfp_frame_check import ssrfp_pkg::*; #(
  parameter int FRAME_LEN   = 5,
  parameter int DIGIT_COUNT = 3
) (
  input  logic [FRAME_LEN-2:0][7:0] frame,
  input  logic [7:0]                last_byte,
  output status_t                   status,
  output logic [RANGE_W-1:0]        range_inches
);

  logic [DIGIT_COUNT-1:0]      dig_ok;
  logic [DIGIT_COUNT-1:0][3:0] dig_val;
  logic [RANGE_W-1:0]          acc;
  logic                        frame_ok;

  // Per-digit classification; a digit slot that reaches the end byte is never a digit.
  for (genvar k = 0; k < DIGIT_COUNT; k++) begin : g_digit
    if (k + 1 < FRAME_LEN - 1) begin : g_in
      assign dig_ok[k]  = (frame[k+1] >= CHAR_ZERO) && (frame[k+1] <= CHAR_NINE);
      assign dig_val[k] = frame[k+1][3:0];
    end else begin : g_out
      assign dig_ok[k]  = 1'b0;
      assign dig_val[k] = 4'd0;
    end
  end

  // Weighted sum of the digits, hundreds first.
  always_comb begin
    acc = '0;
    for (int k = 0; k < DIGIT_COUNT; k++) begin
      acc = acc + RANGE_W'(RANGE_W'(dig_val[k]) * RANGE_W'(digit_weight(k)));
    end
  end

  // The framing bytes take precedence over the digits.
  assign frame_ok = (frame[0] == CHAR_R) && (last_byte == CHAR_CR);

  always_comb begin
    if (!frame_ok) begin
      status       = ST_BAD_FRAME;
      range_inches = '0;
    end else if (!(&dig_ok)) begin
      status       = ST_DIGIT_ERR;
      range_inches = '0;
    end else begin
      status       = ST_OK;
      range_inches = acc;
    end
  end

endmodule

@@ sv/ssrfp_seq.sv @@
// Capture state, frame buffer and per-item result decision of the parser.
// Depends on ssrfp_pkg, ssrfp_frame_check and the assertion macro header.
`include "sonar_serial_range_frame_parser_unit_defines.svh"

module ssrfp_seq import ssrfp_pkg::*; #(
  parameter int FRAME_LEN   = 5,
  parameter int DIGIT_COUNT = 3
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  enabled,
  input  step_t step,
  output res_t  step_res
);

  localparam int FI_W = $clog2(FRAME_LEN);
  localparam int BW   = $clog2(FRAME_LEN - 1);

  logic                      capture_armed;
  logic                      capture_armed_next;
  logic [FI_W-1:0]           frame_index;
  logic [FI_W-1:0]           frame_index_next;
  logic [FRAME_LEN-2:0][7:0] frame_bytes;
  logic                      wr_en;
  logic                      is_last;
  status_t                   chk_status;
  logic [RANGE_W-1:0]        chk_range;

  // The final byte is checked straight from the input, so it is never stored.
  ssrfp_frame_check #(
    .FRAME_LEN   (FRAME_LEN),
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_check (
    .frame        (frame_bytes),
    .last_byte    (step.rx_byte),
    .status       (chk_status),
    .range_inches (chk_range)
  );

  assign is_last = (frame_index == FI_W'(FRAME_LEN - 1));

  // Result and next state for the item currently held in the input register.
  always_comb begin
    step_res           = '{emit: 1'b0, status: ST_OK, range_inches: '0, trigger_pulse: 1'b0};
    capture_armed_next = capture_armed;
    frame_index_next   = frame_index;
    wr_en              = 1'b0;
    if (step.req_type == REQ_START) begin
      step_res.emit = 1'b1;
      if (!enabled) begin
        step_res.status = ST_NOT_ENABLED;
      end else if (capture_armed) begin
        step_res.status = ST_BUSY;
      end else begin
        step_res.trigger_pulse = 1'b1;
        capture_armed_next     = 1'b1;
        frame_index_next       = '0;
      end
    end else if (capture_armed) begin
      if (is_last) begin
        step_res.emit         = 1'b1;
        step_res.status       = chk_status;
        step_res.range_inches = chk_range;
        capture_armed_next    = 1'b0;
        frame_index_next      = '0;
      end else begin
        wr_en            = 1'b1;
        frame_index_next = frame_index + FI_W'(1);
      end
    end
  end

  // Capture state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      capture_armed <= 1'b0;
      frame_index   <= '0;
    end else if (step.go) begin
      capture_armed <= capture_armed_next;
      frame_index   <= frame_index_next;
    end
  end

  // Frame buffer; only the bytes before the end byte are kept.
  always_ff @(posedge clk) begin
    if (step.go && wr_en) begin
      frame_bytes[frame_index[BW-1:0]] <= step.rx_byte;
    end
  end

  `SSRFP_ASSERT_IMP(a_idle_index_zero, !capture_armed, frame_index == '0,
    "frame index not zero while capture is disarmed")
  `SSRFP_ASSERT_NXT(a_start_arms,
    step.go && step.req_type == REQ_START && enabled && !capture_armed,
    capture_armed && frame_index == '0, "accepted start did not arm capture")
  `SSRFP_ASSERT_NXT(a_last_disarms,
    step.go && step.req_type == REQ_BYTE && capture_armed && is_last,
    !capture_armed, "completed frame did not disarm capture")

endmodule

@@ sv/sonar_serial_range_frame_parser_unit.sv @@
// Top level of the serial range frame parser: input register, sequencer, result register.
// Depends on ssrfp_pkg, the channel interfaces in ssrfp_if.sv, ssrfp_seq and the macro header.
//
// Usage. The req channel carries start commands (req_type 0) and received serial bytes
// (req_type 1). A start gives one result: not enabled, busy, or ok with trigger_pulse set.
// Bytes are captured only while a measurement is armed; the byte that completes a frame
// of FRAME_LEN bytes gives one result with the range in inches, a digit error or a bad
// frame status. Other bytes give no result. The cfg channel writes sensor_enabled and is
// always ready; the user must write it only while the block is idle. The block does
// not enforce this. Timing. An item is registered in the input register when accepted,
// and its result is registered in the result register when the item moves on. The block
// accepts one item per cycle unless stalled; the decision for an item is one short pass
// through the sequencer and frame check between the input and result registers.
// Stalls. While the result register holds an item that is not taken, an item that would
// give a result waits in the input register and req.ready falls; an item that gives no
// result still passes. Reset clears the enable, disarms capture and empties both
// registers; the frame buffer needs no clearing.
`include "sonar_serial_range_frame_parser_unit_defines.svh"

module sonar_serial_range_frame_parser_unit import ssrfp_pkg::*; #(
  parameter int FRAME_LEN   = 5,
  parameter int DIGIT_COUNT = 3
) (
  input  logic        clk,
  input  logic        rst,
  ssrfp_cfg_if.sink   cfg,
  ssrfp_req_if.sink   req,
  ssrfp_res_if.source res
);

  logic               sensor_enabled;
  logic               s1_valid;
  logic               s1_req_type;
  logic [7:0]         s1_rx_byte;
  logic               s1_go;
  logic               res_valid;
  status_t            res_status;
  logic [RANGE_W-1:0] res_range;
  logic               res_trigger;
  step_t              step;
  res_t               step_res;

  // Enable register.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_enabled <= 1'b0;
    end else if (cfg.valid) begin
      sensor_enabled <= cfg.sensor_enabled;
    end
  end

  // The held item moves on when it gives no result or the result register can take it.
  assign s1_go     = s1_valid && (!res_valid || res.ready || !step_res.emit);
  assign req.ready = !s1_valid || s1_go;

  assign step = '{go: s1_go, req_type: s1_req_type, rx_byte: s1_rx_byte};

  ssrfp_seq #(
    .FRAME_LEN   (FRAME_LEN),
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .enabled  (sensor_enabled),
    .step     (step),
    .step_res (step_res)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_req_type <= req.req_type;
      s1_rx_byte  <= req.rx_byte;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_go && step_res.emit) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && step_res.emit) begin
      res_status  <= step_res.status;
      res_range   <= step_res.range_inches;
      res_trigger <= step_res.trigger_pulse;
    end
  end

  assign res.valid         = res_valid;
  assign res.status        = res_status;
  assign res.range_inches  = res_range;
  assign res.trigger_pulse = res_trigger;

  `SSRFP_ASSERT_IMP(a_no_overwrite, res_valid && !res.ready, !(s1_go && step_res.emit),
    "result register overwritten while stalled")
  `SSRFP_ASSERT_IMP(a_silent_item_passes, s1_valid && !step_res.emit, s1_go,
    "item without a result was held back")
  `SSRFP_ASSERT_IMP(a_trigger_only_ok, res_valid && res_trigger,
    res_status == ST_OK && res_range == '0, "trigger pulse on a non-start result")

endmodule
